/* design/lcs_pkg.sv */
package lcs_pkg;

   // pixel channel width; every datapath width below follows from it (4 to 16)
   localparam int CHAN_BITS = 8;
   localparam int LANES = 3;
   localparam int SUM_BITS = CHAN_BITS + 2;
   localparam int PROD_BITS = CHAN_BITS + SUM_BITS;
   localparam int NUM_BITS = PROD_BITS + SUM_BITS;
   localparam int DEN_BITS = 2 * SUM_BITS;
   localparam int STEP_BITS = $clog2(CHAN_BITS);

   // queue depth must stay a power of two (pointers wrap by overflow)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // 3 * channel max: reset value of the darkest sum and the stretch scale
   localparam logic [SUM_BITS-1:0] SUM_RESET = SUM_BITS'(3 * ((1 << CHAN_BITS) - 1));
   localparam logic [SUM_BITS-1:0] SCALE = SUM_RESET;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CHAN_BITS - 1);

   localparam logic ACT_MEASURE = 1'b0;
   localparam logic ACT_APPLY = 1'b1;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [SUM_BITS-1:0] sum_type;

   typedef struct packed {
      logic     action;
      logic     first;
      chan_type red_in;
      chan_type green_in;
      chan_type blue_in;
   } pixel_req_type;

   typedef struct packed {
      chan_type red_out;
      chan_type green_out;
      chan_type blue_out;
   } pixel_rsp_type;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_PASS,
      KIND_STRETCH
   } job_kind_type;

   // lane 2 red, lane 1 green, lane 0 blue
   typedef struct packed {
      job_kind_type               kind;
      chan_type [LANES-1:0]       chan;
      sum_type                    sum;
      sum_type                    lift;
      sum_type                    span;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SCALE,
      BK_SAT,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

/* design/lcs_front.sv */
module lcs_front
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  pixel_req_type    req_data,
   output logic             req_stall,
   input  queue_status_type q_status,
   output logic             push_valid,
   output job_type          push_job
);

   sum_type darkest_ff, darkest_in;
   sum_type brightest_ff, brightest_in;
   sum_type pix_sum, base_dark, base_bright;
   logic    accept;

   always_comb begin
      pix_sum = SUM_BITS'(req_data.red_in) + SUM_BITS'(req_data.green_in)
              + SUM_BITS'(req_data.blue_in);
      // only apply beats need a queue slot
      req_stall = q_status.full && (req_data.action == ACT_APPLY);
      accept = req_valid && !req_stall;

      base_dark = req_data.first ? SUM_RESET : darkest_ff;
      base_bright = req_data.first ? '0 : brightest_ff;
      darkest_in = darkest_ff;
      brightest_in = brightest_ff;
      if (accept && (req_data.action == ACT_MEASURE)) begin
         darkest_in = (pix_sum < base_dark) ? pix_sum : base_dark;
         brightest_in = (pix_sum > base_bright) ? pix_sum : base_bright;
      end

      push_valid = accept && (req_data.action == ACT_APPLY);
      push_job.chan = {req_data.red_in, req_data.green_in, req_data.blue_in};
      push_job.sum = pix_sum;
      push_job.lift = pix_sum - darkest_ff;
      push_job.span = brightest_ff - darkest_ff;
      priority if (pix_sum == '0) begin
         push_job.kind = KIND_ZERO;
      end else if (brightest_ff <= darkest_ff) begin
         push_job.kind = KIND_PASS;
      end else if (pix_sum < darkest_ff) begin
         push_job.kind = KIND_ZERO;
      end else begin
         push_job.kind = KIND_STRETCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         darkest_ff <= SUM_RESET;
         brightest_ff <= '0;
      end else begin
         darkest_ff <= darkest_in;
         brightest_ff <= brightest_in;
      end
   end

endmodule

/* design/lcs_queue.sv */
module lcs_queue
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      q_status.full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
      q_status.not_empty = (count_ff != '0);
      do_push = push_valid && !q_status.full;
      do_pop = pop && q_status.not_empty;
      head_job = slot_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_BITS'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/lcs_back.sv */
module lcs_back
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pixel_rsp_type    rsp_data
);

   back_state_type          state_ff, state_in;
   chan_type                chan_ff [LANES];
   sum_type                 sum_ff, lift_ff, span_ff;
   logic [PROD_BITS-1:0]    prod_ff [LANES];
   logic [DEN_BITS-1:0]     den_ff;
   logic [NUM_BITS-1:0]     rem_ff [LANES];
   logic [NUM_BITS-1:0]     dsr_ff;
   chan_type                q_ff [LANES];
   logic [LANES-1:0]        sat_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic [LANES-1:0]        fits;
   logic                    out_load;
   logic                    rsp_valid_ff;
   pixel_rsp_type           rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) begin
               state_in = (head_job.kind == KIND_STRETCH) ? BK_MUL : BK_DONE;
            end
         end
         BK_MUL:   state_in = BK_SCALE;
         BK_SCALE: state_in = BK_SAT;
         BK_SAT:   state_in = BK_DIV;
         BK_DIV: begin
            if (step_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop = (state_ff == BK_IDLE) && q_status.not_empty;
      out_load = (state_ff == BK_DONE) && (!rsp_valid_ff || !rsp_stall);
      for (int i = 0; i < LANES; i++) begin
         fits[i] = (rem_ff[i] >= dsr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: three channel lanes share one divisor
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               for (int i = 0; i < LANES; i++) begin
                  chan_ff[i] <= head_job.chan[i];
                  q_ff[i] <= (head_job.kind == KIND_PASS) ? head_job.chan[i] : '0;
               end
               sat_ff <= '0;
               sum_ff <= head_job.sum;
               lift_ff <= head_job.lift;
               span_ff <= head_job.span;
            end
         end
         BK_MUL: begin
            for (int i = 0; i < LANES; i++) begin
               prod_ff[i] <= PROD_BITS'(chan_ff[i]) * PROD_BITS'(lift_ff);
            end
            den_ff <= DEN_BITS'(sum_ff) * DEN_BITS'(span_ff);
         end
         BK_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               rem_ff[i] <= NUM_BITS'(prod_ff[i]) * NUM_BITS'(SCALE);
            end
            dsr_ff <= NUM_BITS'(den_ff) << (CHAN_BITS - 1);
            step_ff <= LAST_STEP;
         end
         BK_SAT: begin
            // quotient of 2^CHAN_BITS or more saturates
            for (int i = 0; i < LANES; i++) begin
               sat_ff[i] <= ({1'b0, rem_ff[i]} >= {dsr_ff, 1'b0});
            end
         end
         BK_DIV: begin
            for (int i = 0; i < LANES; i++) begin
               if (fits[i]) begin
                  rem_ff[i] <= rem_ff[i] - dsr_ff;
               end
               q_ff[i] <= {q_ff[i][CHAN_BITS-2:0], fits[i]};
            end
            dsr_ff <= dsr_ff >> 1;
            step_ff <= step_ff - 1'b1;
         end
         BK_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.red_out <= sat_ff[2] ? '1 : q_ff[2];
         rsp_data_ff.green_out <= sat_ff[1] ? '1 : q_ff[1];
         rsp_data_ff.blue_out <= sat_ff[0] ? '1 : q_ff[0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* design/luma_contrast_stretch.sv */
// measure beats: taken one per cycle unless an apply beat is blocked on a full queue
// apply beats: black or flat-range pixels go through the queue, the back end's IDLE and
//   DONE states and the output register; stretched pixels also pass MUL, SCALE, SAT and DIV
// back end takes one pixel at a time, popping the next only in IDLE; the restoring
//   divider yields one quotient bit per cycle per lane; black or flat pixels skip it
// reset: synchronous; extremes go to 3 * channel max and 0, queue and result empty
module luma_contrast_stretch
   import lcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pixel_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output pixel_rsp_type rsp_data
);

   // front to queue
   logic             push_valid;
   job_type          push_job;
   // queue to back
   job_type          head_job;
   logic             pop;
   queue_status_type q_status;

   // front: tracks the running min/max sum on measure beats, classifies apply beats
   // (black, flat range, below minimum, stretch) against the extremes seen so far
   lcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // short queue decouples classification from the divider
   lcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   // back: for stretch jobs multiply, scale by 3 * max, check saturation, then one
   // shared-divisor restoring divide per channel lane; results are held in the output register
   lcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push_valid)
      else $error("push into full queue");

   // back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from empty queue");

   // a measure beat never turns into a job
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.action == ACT_MEASURE)) |-> !push_valid)
      else $error("measure beat queued");

   // result register comes out of reset empty
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

/* tb/luma_contrast_stretch_test.sv */
`timescale 1ns / 100ps

module luma_contrast_stretch_test;
   import lcs_pkg::*;

   // largest channel value, as a plain integer for the arithmetic below
   localparam int CHAN_TOP = (1 << CHAN_BITS) - 1;
   // drain window, sized from the back end's time per stretched pixel
   localparam int DRAIN_CYCLES = 4 * (CHAN_BITS + 5) + 20;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 610;
   localparam int REPORT_LIMIT = 10;

   // a directed row either carries its expected pixel or leaves it to the predictor
   localparam logic TYPED = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      pixel_req_type px;
      logic          typed;
      pixel_rsp_type want;
   } directed_row_type;

   // shapes of random pixel content
   typedef enum int {
      STYLE_SPREAD,
      STYLE_NEAR,
      STYLE_CORNER,
      STYLE_DARK
   } pixel_style_type;

   localparam int DIRECTED_COUNT = 25;

   // directed beats: black and flat-range right after reset, first flag on apply,
   // equal extremes, full range, below minimum, above maximum, a cleared range
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // nothing measured yet: black, then pass-through
      '{'{ACT_APPLY,   1'b0, 8'd0,   8'd0,   8'd0},   TYPED,     '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd255, 8'd255, 8'd255}, TYPED,     '{8'd255, 8'd255, 8'd255}},
      '{'{ACT_APPLY,   1'b1, 8'd1,   8'd2,   8'd3},   TYPED,     '{8'd1,   8'd2,   8'd3}},
      // one measured pixel: equal extremes pass the pixel through
      '{'{ACT_MEASURE, 1'b1, 8'd10,  8'd20,  8'd30},  PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd10,  8'd20,  8'd30},  TYPED,     '{8'd10,  8'd20,  8'd30}},
      // widen to the full range 0 .. 765
      '{'{ACT_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255}, PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_MEASURE, 1'b0, 8'd0,   8'd0,   8'd0},   PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd255, 8'd255, 8'd255}, TYPED,     '{8'd255, 8'd255, 8'd255}},
      '{'{ACT_APPLY,   1'b0, 8'd0,   8'd0,   8'd0},   TYPED,     '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd1,   8'd0,   8'd0},   PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd128, 8'd64,  8'd32},  PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd0,   8'd0,   8'd255}, PREDICTED, '{8'd0,   8'd0,   8'd0}},
      // clear and measure a narrow range 150 .. 300
      '{'{ACT_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100}, PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_MEASURE, 1'b0, 8'd50,  8'd50,  8'd50},  PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd10,  8'd10,  8'd10},  TYPED,     '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd200, 8'd200, 8'd200}, TYPED,     '{8'd255, 8'd255, 8'd255}},
      '{'{ACT_APPLY,   1'b0, 8'd255, 8'd0,   8'd0},   PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd50,  8'd50,  8'd50},  TYPED,     '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd75,  8'd75,  8'd75},  PREDICTED, '{8'd0,   8'd0,   8'd0}},
      // first flag on an apply beat must leave the range alone
      '{'{ACT_APPLY,   1'b1, 8'd100, 8'd100, 8'd100}, PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_MEASURE, 1'b0, 8'd120, 8'd120, 8'd120}, PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd255, 8'd128, 8'd1},   PREDICTED, '{8'd0,   8'd0,   8'd0}},
      // range cleared down to a single black pixel: flat again
      '{'{ACT_MEASURE, 1'b1, 8'd0,   8'd0,   8'd0},   PREDICTED, '{8'd0,   8'd0,   8'd0}},
      '{'{ACT_APPLY,   1'b0, 8'd5,   8'd5,   8'd5},   TYPED,     '{8'd5,   8'd5,   8'd5}},
      '{'{ACT_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255}, PREDICTED, '{8'd0,   8'd0,   8'd0}}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   pixel_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   pixel_rsp_type rsp_data;

   // predictor state: running darkest and brightest channel sum
   sum_type       low_sum = SUM_RESET;
   sum_type       high_sum = '0;

   // pixels still owed by the block, oldest first
   pixel_rsp_type expected_pixels [$];
   pixel_rsp_type oldest_pixel;
   int            mismatches = 0;

   // idle rates in percent, and the long receiver hold-off
   int            send_pct = 0;
   int            recv_pct = 0;
   logic          hold_wanted = 1'b0;
   logic          hold_started = 1'b0;
   int            hold_left = 0;

   luma_contrast_stretch u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // run limit, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("luma_contrast_stretch_test NOT OK");
      $finish;
   end

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("error at %0t: %0s", $realtime, msg);
      end
   endfunction

   // one channel: c * 3 * (s - low) * max / (s * (high - low)), saturated
   function automatic chan_type stretch_chan(chan_type level, sum_type total);
      longint unsigned lift, span, top, bottom, quot;
      lift = 64'(total - low_sum);
      span = 64'(high_sum - low_sum);
      top = 64'(level);
      top = top * 3 * lift * CHAN_TOP;
      bottom = 64'(total);
      bottom = bottom * span;
      quot = top / bottom;
      return (quot > CHAN_TOP) ? chan_type'(CHAN_TOP) : chan_type'(quot);
   endfunction

   // measure beats move the extremes, apply beats owe one result pixel
   function automatic void predict_pixel(pixel_req_type px);
      sum_type       total;
      pixel_rsp_type res;
      total = SUM_BITS'(px.red_in) + SUM_BITS'(px.green_in) + SUM_BITS'(px.blue_in);
      if (px.action == ACT_MEASURE) begin
         if (px.first) begin
            low_sum = SUM_RESET;
            high_sum = '0;
         end
         if (total < low_sum) low_sum = total;
         if (total > high_sum) high_sum = total;
      end else begin
         if (total == 0) begin
            // black pixel
            res = '0;
         end else if (high_sum <= low_sum) begin
            // flat range, also the never-measured case
            res.red_out = px.red_in;
            res.green_out = px.green_in;
            res.blue_out = px.blue_in;
         end else if (total < low_sum) begin
            // darker than anything measured
            res = '0;
         end else begin
            res.red_out = stretch_chan(px.red_in, total);
            res.green_out = stretch_chan(px.green_in, total);
            res.blue_out = stretch_chan(px.blue_in, total);
         end
         expected_pixels.push_back(res);
      end
   endfunction

   function automatic chan_type pick_chan(pixel_style_type style, chan_type base);
      int v;
      case (style)
         STYLE_SPREAD: v = int'($urandom_range(0, CHAN_TOP));
         STYLE_NEAR: begin
            // narrow range around a base level, clamped to the channel range
            v = int'(base) + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > CHAN_TOP) v = CHAN_TOP;
         end
         STYLE_CORNER: v = $urandom_range(0, 1) ? CHAN_TOP : 0;
         default: v = int'($urandom_range(0, 3));
      endcase
      return chan_type'(v);
   endfunction

   function automatic pixel_req_type make_pixel(logic act, logic first_flag,
                                                pixel_style_type style, chan_type base);
      pixel_req_type px;
      px.action = act;
      px.first = first_flag;
      px.red_in = pick_chan(style, base);
      px.green_in = pick_chan(style, base);
      px.blue_in = pick_chan(style, base);
      return px;
   endfunction

   // offer one beat, entered and left just after a falling edge;
   // the expectation is booked at the edge that takes the beat
   task automatic send_pixel(input pixel_req_type px, input logic typed,
                             input pixel_rsp_type want);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) begin
         expected_pixels.push_back(want);
      end else begin
         predict_pixel(px);
      end
      @(negedge clock);
   endtask

   // idle rates change on a rising edge so the receiver sees them cleanly
   task automatic set_idling(input int send_rate, input int recv_rate, input logic hold);
      @(posedge clock);
      send_pct = send_rate;
      recv_pct = recv_rate;
      if (hold) hold_wanted = 1'b1;
      @(negedge clock);
   endtask

   // random frames: mostly a measure pass opened by first, then an apply pass;
   // the rest is noise with action and first picked at random
   task automatic run_frames(input int beat_goal);
      int              sent;
      int              n_measure;
      int              n_apply;
      pixel_style_type style;
      chan_type        base;
      sent = 0;
      while (sent < beat_goal) begin
         style = pixel_style_type'($urandom_range(0, 3));
         base = chan_type'($urandom_range(0, CHAN_TOP));
         if ($urandom_range(0, 9) < 8) begin
            n_measure = $urandom_range(1, 10);
            for (int i = 0; i < n_measure; i++) begin
               send_pixel(make_pixel(ACT_MEASURE, i == 0, style, base), PREDICTED, '0);
            end
            n_apply = $urandom_range(1, 16);
            for (int i = 0; i < n_apply; i++) begin
               // first is ignored on apply beats, so toggle it anyway
               send_pixel(make_pixel(ACT_APPLY, 1'($urandom_range(0, 1)), style, base),
                          PREDICTED, '0);
            end
            sent += n_measure + n_apply;
         end else begin
            n_measure = $urandom_range(1, 8);
            for (int i = 0; i < n_measure; i++) begin
               style = pixel_style_type'($urandom_range(0, 3));
               send_pixel(make_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     style, base), PREDICTED, '0);
            end
            sent += n_measure;
         end
      end
   endtask

   // receiver: random stalls, or one long hold-off counted here
   always @(negedge clock) begin
      if (hold_wanted && !hold_started) begin
         hold_started = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
   end

   // result checker: every taken beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            flag_error($sformatf("unexpected pixel %0d/%0d/%0d", rsp_data.red_out,
                                 rsp_data.green_out, rsp_data.blue_out));
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            if (rsp_data.red_out !== oldest_pixel.red_out)
               flag_error($sformatf("red expected %0d got %0d",
                                    oldest_pixel.red_out, rsp_data.red_out));
            if (rsp_data.green_out !== oldest_pixel.green_out)
               flag_error($sformatf("green expected %0d got %0d",
                                    oldest_pixel.green_out, rsp_data.green_out));
            if (rsp_data.blue_out !== oldest_pixel.blue_out)
               flag_error($sformatf("blue expected %0d got %0d",
                                    oldest_pixel.blue_out, rsp_data.blue_out));
         end
      end
   end

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      // sender mostly busy, receiver stalls often
      set_idling(18, 58, 1'b0);
      run_frames(PHASE_BEATS);
      // the other way round
      set_idling(58, 18, 1'b0);
      run_frames(PHASE_BEATS);
      // full rate, opened by a long receiver hold-off that backs up the input
      set_idling(0, 0, 1'b1);
      run_frames(PHASE_BEATS);

      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      // a stray extra pixel would show up in this window
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         flag_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
      end

      if (mismatches == 0) begin
         $display("luma_contrast_stretch_test OK");
      end else begin
         $display("luma_contrast_stretch_test NOT OK");
      end
      $finish;
   end

endmodule
